### sv/sae_pkg.sv
// Package: constants, item types, FSM and command types of the edge store.
`default_nettype none
package sae_pkg;
    localparam int MAX_VERTICES = 1024;
    localparam int MAX_EDGES    = 8192;
    localparam int BATCH_MAX    = 64;

    localparam int VW    = $clog2(MAX_VERTICES);
    localparam int CW    = $clog2(MAX_EDGES) + 1;
    localparam int NAW   = $clog2(MAX_EDGES);
    localparam int LSD   = MAX_VERTICES + 1;
    localparam int LSAW  = $clog2(LSD);
    localparam int BAW   = $clog2(BATCH_MAX);
    localparam int FW    = BAW + 1;
    localparam int KW    = 2 * VW;
    localparam int NEEDW = CW + 1;
    localparam int NCW   = 11;

    localparam logic [1:0] STAT_OK    = 2'd0;
    localparam logic [1:0] STAT_RANGE = 2'd1;
    localparam logic [1:0] STAT_FULL  = 2'd2;

    typedef struct packed {
        logic        func;
        logic [15:0] vertex_a;
        logic [15:0] vertex_b;
        logic        batch_last;
    } t_in_item;

    typedef struct packed {
        logic       found;
        logic [1:0] status;
        logic       is_insert_ack;
    } t_out_item;

    typedef enum logic [4:0] {
        S_CLEAR, S_IDLE, S_QCHK, S_LS0, S_LS1, S_LS2, S_BS0, S_BS1, S_SRET,
        S_CLOSE, S_A_TOP, S_A_CAP, S_A_DUP, S_A_DUPC, S_A_CHK, S_B_TOP,
        S_B_CAP, S_SH_TOP, S_SH_WR, S_LS_RD, S_LS_WR, S_B_NEXT, S_RESP
    } t_state;

    typedef enum logic [1:0] {
        MODE_QUERY, MODE_COUNT, MODE_MERGE
    } t_mode;

    typedef enum logic [4:0] {
        OP_NOP, OP_CLR, OP_ACCEPT, OP_SRCH, OP_CAPLO, OP_CAPHI, OP_RDMID, OP_CMP,
        OP_AINIT, OP_RDBI, OP_CAPKEY, OP_RDBJ, OP_JINC, OP_ANEXT, OP_INEXT,
        OP_BINIT, OP_SHINIT, OP_RDSH, OP_WRSH, OP_WRNEW, OP_RDLSW, OP_WRLSW,
        OP_REJR, OP_REJF, OP_RESP
    } t_op;

    typedef struct packed {
        t_op op;
    } t_cmd;

    typedef struct packed {
        logic clr_done;
        logic inrange;
        logic lt;
        logic eq;
        logic dup_eq;
        logic j_lt_i;
        logic i_lt_fill;
        logic bad;
        logic over;
        logic need_over;
        logic ptr_gt_lo;
        logic w_last;
        logic hit;
    } t_stat;
endpackage
`default_nettype wire

### sv/sae_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module sae_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule
`default_nettype wire

### sv/sae_datapath.sv
// Datapath: list offsets, neighbor store, batch buffer and search/merge registers.
`default_nettype none
module sae_datapath (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire sae_pkg::t_cmd      i_cmd,
    input  wire sae_pkg::t_in_item  i_in,
    input  wire logic [10:0]        i_n,
    output sae_pkg::t_stat          o_stat,
    output sae_pkg::t_out_item      o_out
);
    import sae_pkg::*;

    logic [VW-1:0]    r_u, r_v;
    logic [CW-1:0]    r_lo, r_hi, r_total, r_ptr;
    logic [NEEDW-1:0] r_need;
    logic [FW-1:0]    r_fill, r_i, r_j;
    logic             r_bad, r_over, r_hit, r_ack, r_inr;
    logic [1:0]       r_status;
    logic [KW-1:0]    r_key;
    logic [LSAW-1:0]  r_w, r_clr;

    logic             ls_we, nb_we, bb_we;
    logic [LSAW-1:0]  ls_waddr, ls_raddr;
    logic [CW-1:0]    ls_wdata, ls_rdata;
    logic [NAW-1:0]   nb_waddr, nb_raddr;
    logic [VW-1:0]    nb_wdata, nb_rdata;
    logic [BAW-1:0]   bb_waddr, bb_raddr;
    logic [KW-1:0]    bb_wdata, bb_rdata;

    logic [15:0]      big, little;
    logic             inr;
    logic [CW-1:0]    mid;

    assign big    = (i_in.vertex_a < i_in.vertex_b) ? i_in.vertex_b : i_in.vertex_a;
    assign little = (i_in.vertex_a < i_in.vertex_b) ? i_in.vertex_a : i_in.vertex_b;
    assign inr    = big < {5'd0, i_n};
    assign mid    = r_lo + ((r_hi - r_lo) >> 1);

    sae_ram #(.WIDTH(CW), .DEPTH(LSD)) u_ls (
        .i_clk(i_clk), .i_we(ls_we), .i_waddr(ls_waddr), .i_wdata(ls_wdata),
        .i_raddr(ls_raddr), .o_rdata(ls_rdata)
    );
    sae_ram #(.WIDTH(VW), .DEPTH(MAX_EDGES)) u_nb (
        .i_clk(i_clk), .i_we(nb_we), .i_waddr(nb_waddr), .i_wdata(nb_wdata),
        .i_raddr(nb_raddr), .o_rdata(nb_rdata)
    );
    sae_ram #(.WIDTH(KW), .DEPTH(BATCH_MAX)) u_bb (
        .i_clk(i_clk), .i_we(bb_we), .i_waddr(bb_waddr), .i_wdata(bb_wdata),
        .i_raddr(bb_raddr), .o_rdata(bb_rdata)
    );

    always_comb begin
        ls_we    = 1'b0;
        ls_waddr = r_w;
        ls_wdata = ls_rdata + CW'(1);
        ls_raddr = r_w;
        nb_we    = 1'b0;
        nb_waddr = r_ptr[NAW-1:0];
        nb_wdata = nb_rdata;
        nb_raddr = mid[NAW-1:0];
        bb_we    = 1'b0;
        bb_waddr = r_fill[BAW-1:0];
        bb_wdata = {big[VW-1:0], little[VW-1:0]};
        bb_raddr = r_i[BAW-1:0];
        case (i_cmd.op)
            OP_CLR: begin
                ls_we    = 1'b1;
                ls_waddr = r_clr;
                ls_wdata = '0;
            end
            OP_ACCEPT: bb_we = i_in.func && inr && (r_fill < FW'(BATCH_MAX));
            OP_SRCH:   ls_raddr = LSAW'(r_u);
            OP_CAPLO:  ls_raddr = LSAW'(r_u) + LSAW'(1);
            OP_RDBJ:   bb_raddr = r_j[BAW-1:0];
            OP_RDSH: begin
                nb_raddr = NAW'(r_ptr - CW'(1));
            end
            OP_WRSH:   nb_we = 1'b1;
            OP_WRNEW: begin
                nb_we    = 1'b1;
                nb_waddr = r_lo[NAW-1:0];
                nb_wdata = r_v;
            end
            OP_WRLSW:  ls_we = 1'b1;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill  <= '0;
            r_bad   <= 1'b0;
            r_over  <= 1'b0;
            r_total <= '0;
            r_clr   <= '0;
        end else begin
            case (i_cmd.op)
                OP_CLR: r_clr <= r_clr + LSAW'(1);
                OP_ACCEPT: begin
                    r_u      <= big[VW-1:0];
                    r_v      <= little[VW-1:0];
                    r_inr    <= inr;
                    r_hit    <= 1'b0;
                    r_ack    <= i_in.func;
                    r_status <= STAT_OK;
                    if (i_in.func) begin
                        if (!inr) begin
                            r_bad <= 1'b1;
                        end else if (r_fill >= FW'(BATCH_MAX)) begin
                            r_over <= 1'b1;
                        end else begin
                            r_fill <= r_fill + FW'(1);
                        end
                    end
                end
                OP_SRCH:  r_hit <= 1'b0;
                OP_CAPLO: r_lo <= ls_rdata;
                OP_CAPHI: r_hi <= ls_rdata;
                OP_CMP: begin
                    if (nb_rdata == r_v) begin
                        r_hit <= 1'b1;
                    end else if (nb_rdata < r_v) begin
                        r_lo <= mid + CW'(1);
                    end else begin
                        r_hi <= mid;
                    end
                end
                OP_AINIT: begin
                    r_i    <= '0;
                    r_need <= NEEDW'(r_total);
                end
                OP_CAPKEY: begin
                    r_key <= bb_rdata;
                    r_u   <= bb_rdata[KW-1:VW];
                    r_v   <= bb_rdata[VW-1:0];
                    r_j   <= '0;
                end
                OP_JINC: r_j <= r_j + FW'(1);
                OP_ANEXT: begin
                    if (!r_hit) begin
                        r_need <= r_need + NEEDW'(1);
                    end
                    r_i <= r_i + FW'(1);
                end
                OP_INEXT:  r_i <= r_i + FW'(1);
                OP_BINIT:  r_i <= '0;
                OP_SHINIT: r_ptr <= r_total;
                OP_WRSH:   r_ptr <= r_ptr - CW'(1);
                OP_WRNEW: begin
                    r_w     <= LSAW'(r_u) + LSAW'(1);
                    r_total <= r_total + CW'(1);
                end
                OP_WRLSW: r_w <= r_w + LSAW'(1);
                OP_REJR:  r_status <= STAT_RANGE;
                OP_REJF:  r_status <= STAT_FULL;
                OP_RESP: begin
                    if (r_ack) begin
                        r_fill <= '0;
                        r_bad  <= 1'b0;
                        r_over <= 1'b0;
                    end
                end
                default: ;
            endcase
        end
    end

    always_comb begin
        o_stat.clr_done  = r_clr == LSAW'(MAX_VERTICES);
        o_stat.inrange   = r_inr;
        o_stat.lt        = r_lo < r_hi;
        o_stat.eq        = nb_rdata == r_v;
        o_stat.dup_eq    = bb_rdata == r_key;
        o_stat.j_lt_i    = r_j < r_i;
        o_stat.i_lt_fill = r_i < r_fill;
        o_stat.bad       = r_bad;
        o_stat.over      = r_over;
        o_stat.need_over = r_need > NEEDW'(MAX_EDGES);
        o_stat.ptr_gt_lo = r_ptr > r_lo;
        o_stat.w_last    = r_w == LSAW'(MAX_VERTICES);
        o_stat.hit       = r_hit;
    end

    assign o_out.found         = r_hit & ~r_ack;
    assign o_out.status        = r_status;
    assign o_out.is_insert_ack = r_ack;

`ifndef NO_ASSERTIONS
    a_fill_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= FW'(BATCH_MAX)) else $error("batch fill above limit");
    a_total_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_total <= CW'(MAX_EDGES)) else $error("store count above limit");
    a_shift_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.op == OP_WRNEW |-> r_total < CW'(MAX_EDGES)) else $error("insert into full store");
`endif
endmodule
`default_nettype wire

### sv/sae_ctrl.sv
// Controller: sequences clear, query search, batch count and merge.
`default_nettype none
module sae_ctrl (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_start,
    input  wire logic           i_func,
    input  wire logic           i_last,
    input  wire sae_pkg::t_stat i_stat,
    output sae_pkg::t_cmd       o_cmd,
    output logic                o_busy,
    output logic                o_valid
);
    import sae_pkg::*;

    t_state r_state, n_state;
    t_mode  r_mode, n_mode;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_mode  <= MODE_QUERY;
        end else begin
            r_state <= n_state;
            r_mode  <= n_mode;
        end
    end

    always_comb begin
        n_state  = r_state;
        n_mode   = r_mode;
        o_cmd.op = OP_NOP;
        o_busy   = r_state != S_IDLE;
        o_valid  = 1'b0;
        case (r_state)
            S_CLEAR: begin
                o_cmd.op = OP_CLR;
                if (i_stat.clr_done) n_state = S_IDLE;
            end
            S_IDLE: begin
                if (i_start) begin
                    o_cmd.op = OP_ACCEPT;
                    if (!i_func) begin
                        n_state = S_QCHK;
                    end else if (i_last) begin
                        n_state = S_CLOSE;
                    end
                end
            end
            S_QCHK: begin
                n_mode  = MODE_QUERY;
                n_state = i_stat.inrange ? S_LS0 : S_RESP;
            end
            S_LS0: begin
                o_cmd.op = OP_SRCH;
                n_state  = S_LS1;
            end
            S_LS1: begin
                o_cmd.op = OP_CAPLO;
                n_state  = S_LS2;
            end
            S_LS2: begin
                o_cmd.op = OP_CAPHI;
                n_state  = S_BS0;
            end
            S_BS0: begin
                if (i_stat.lt) begin
                    o_cmd.op = OP_RDMID;
                    n_state  = S_BS1;
                end else begin
                    n_state = S_SRET;
                end
            end
            S_BS1: begin
                o_cmd.op = OP_CMP;
                n_state  = i_stat.eq ? S_SRET : S_BS0;
            end
            S_SRET: begin
                case (r_mode)
                    MODE_COUNT: begin
                        o_cmd.op = OP_ANEXT;
                        n_state  = S_A_TOP;
                    end
                    MODE_MERGE: begin
                        if (i_stat.hit) begin
                            o_cmd.op = OP_INEXT;
                            n_state  = S_B_TOP;
                        end else begin
                            o_cmd.op = OP_SHINIT;
                            n_state  = S_SH_TOP;
                        end
                    end
                    default: n_state = S_RESP;
                endcase
            end
            S_CLOSE: begin
                if (i_stat.bad) begin
                    o_cmd.op = OP_REJR;
                    n_state  = S_RESP;
                end else if (i_stat.over) begin
                    o_cmd.op = OP_REJF;
                    n_state  = S_RESP;
                end else begin
                    o_cmd.op = OP_AINIT;
                    n_state  = S_A_TOP;
                end
            end
            S_A_TOP: begin
                if (i_stat.i_lt_fill) begin
                    o_cmd.op = OP_RDBI;
                    n_state  = S_A_CAP;
                end else begin
                    n_state = S_A_CHK;
                end
            end
            S_A_CAP: begin
                o_cmd.op = OP_CAPKEY;
                n_state  = S_A_DUP;
            end
            S_A_DUP: begin
                if (i_stat.j_lt_i) begin
                    o_cmd.op = OP_RDBJ;
                    n_state  = S_A_DUPC;
                end else begin
                    n_mode  = MODE_COUNT;
                    n_state = S_LS0;
                end
            end
            S_A_DUPC: begin
                if (i_stat.dup_eq) begin
                    o_cmd.op = OP_INEXT;
                    n_state  = S_A_TOP;
                end else begin
                    o_cmd.op = OP_JINC;
                    n_state  = S_A_DUP;
                end
            end
            S_A_CHK: begin
                if (i_stat.need_over) begin
                    o_cmd.op = OP_REJF;
                    n_state  = S_RESP;
                end else begin
                    o_cmd.op = OP_BINIT;
                    n_state  = S_B_TOP;
                end
            end
            S_B_TOP: begin
                if (i_stat.i_lt_fill) begin
                    o_cmd.op = OP_RDBI;
                    n_state  = S_B_CAP;
                end else begin
                    n_state = S_RESP;
                end
            end
            S_B_CAP: begin
                o_cmd.op = OP_CAPKEY;
                n_mode   = MODE_MERGE;
                n_state  = S_LS0;
            end
            S_SH_TOP: begin
                if (i_stat.ptr_gt_lo) begin
                    o_cmd.op = OP_RDSH;
                    n_state  = S_SH_WR;
                end else begin
                    o_cmd.op = OP_WRNEW;
                    n_state  = S_LS_RD;
                end
            end
            S_SH_WR: begin
                o_cmd.op = OP_WRSH;
                n_state  = S_SH_TOP;
            end
            S_LS_RD: begin
                o_cmd.op = OP_RDLSW;
                n_state  = S_LS_WR;
            end
            S_LS_WR: begin
                o_cmd.op = OP_WRLSW;
                n_state  = i_stat.w_last ? S_B_NEXT : S_LS_RD;
            end
            S_B_NEXT: begin
                o_cmd.op = OP_INEXT;
                n_state  = S_B_TOP;
            end
            S_RESP: begin
                o_cmd.op = OP_RESP;
                o_valid  = 1'b1;
                n_state  = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end
endmodule
`default_nettype wire

### sv/sorted_adjacency_edge_store_top.sv
// Top level: APB register, controller and datapath of the edge store.
// Query: read of the two list offsets, then a binary search of the neighbor list; a query
// whose larger endpoint is out of range answers with no search. Insert without last mark: no result.
// Closing insert: a batch with an out-of-range or surplus edge is rejected; else a dedup/count pass
// (rejects if the store would overflow), then per new edge a tail shift and an offset update above it.
// One item at a time, results never stall; reset: synchronous, offset clear, busy high.
`default_nettype none
module sorted_adjacency_edge_store_top (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               start,
    output logic                    busy,
    input  wire sae_pkg::t_in_item  i_in,
    output logic                    o_valid,
    output sae_pkg::t_out_item      o_out,
    input  wire logic               psel,
    input  wire logic               penable,
    input  wire logic               pwrite,
    input  wire logic [2:0]         paddr,
    input  wire logic [31:0]        pwdata,
    output logic [31:0]             prdata,
    output logic                    pready
);
    import sae_pkg::*;

    logic [NCW-1:0] r_vcount;
    logic [NCW-1:0] act_n;
    t_cmd           cmd;
    t_stat          stat;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vcount <= NCW'(MAX_VERTICES);
        end else if (psel && penable && pwrite && !paddr[2]) begin
            r_vcount <= pwdata[NCW-1:0];
        end
    end

    assign pready = 1'b1;
    assign prdata = paddr[2] ? 32'd0 : {{(32-NCW){1'b0}}, r_vcount};
    assign act_n  = (r_vcount > NCW'(MAX_VERTICES)) ? NCW'(MAX_VERTICES) : r_vcount;

    sae_ctrl u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(start), .i_func(i_in.func),
        .i_last(i_in.batch_last), .i_stat(stat), .o_cmd(cmd), .o_busy(busy),
        .o_valid(o_valid)
    );

    sae_datapath u_dp (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cmd(cmd), .i_in(i_in), .i_n(act_n),
        .o_stat(stat), .o_out(o_out)
    );

`ifndef NO_ASSERTIONS
    a_strobe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |=> !o_valid) else $error("result strobe longer than one cycle");
    a_valid_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> busy) else $error("result while idle");
    a_query_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy && !i_in.func |=> busy) else $error("query not taken up");
`endif
endmodule
`default_nettype wire
